FILE: hw/rtl/akbd_pkg.sv
package akbd_pkg;

	localparam int unsigned KEY_ROWS = 64;
	localparam int unsigned ROW_W    = 6;
	localparam int unsigned PERM_CNT = 24;

	typedef struct packed {
		logic [4:0] perm;
		logic [7:0] mask;
	} key_t;

	localparam int unsigned KEY_W = $bits(key_t);

	// stage advance strobes shared by both key lanes
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} stage_ctl_t;

	// source bit pairs for output bits 6, 4, 2 and 0, as bit index / 2
	localparam logic [7:0] PERM_SEL [PERM_CNT] = '{
		{2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0},
		{2'd1, 2'd2, 2'd3, 2'd0}, {2'd0, 2'd2, 2'd1, 2'd3},
		{2'd3, 2'd1, 2'd2, 2'd0}, {2'd3, 2'd0, 2'd1, 2'd2},
		{2'd3, 2'd2, 2'd0, 2'd1}, {2'd1, 2'd3, 2'd2, 2'd0},
		{2'd2, 2'd1, 2'd3, 2'd0}, {2'd2, 2'd3, 2'd0, 2'd1},
		{2'd3, 2'd0, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1},
		{2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
		{2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2},
		{2'd0, 2'd3, 2'd1, 2'd2}, {2'd1, 2'd0, 2'd3, 2'd2},
		{2'd0, 2'd1, 2'd3, 2'd2}, {2'd2, 2'd1, 2'd0, 2'd3},
		{2'd1, 2'd2, 2'd0, 2'd3}, {2'd2, 2'd0, 2'd1, 2'd3},
		{2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
	};

	// indices past the table saturate to the last arrangement
	function automatic logic [7:0] perm_sel(input logic [4:0] p);
		logic [4:0] idx;
		idx = (p >= 5'(PERM_CNT)) ? 5'(PERM_CNT - 1) : p;
		return PERM_SEL[idx];
	endfunction

	typedef enum logic {
		ACT_DECODE = 1'b0,
		ACT_WRITE  = 1'b1
	} action_t;

	typedef enum logic {
		ROLE_OPCODE = 1'b0,
		ROLE_DATA   = 1'b1
	} key_role_t;

endpackage

FILE: hw/rtl/akbd_ram.sv
module akbd_ram #(
	parameter int unsigned WIDTH = 13,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/akbd_lane.sv
module akbd_lane (
	input  logic                clk,
	input  akbd_pkg::stage_ctl_t ctl,
	input  logic [7:0]          cipher_s1,
	input  akbd_pkg::key_t      key_s1,
	output logic [7:0]          plain_s3
);

	import akbd_pkg::*;

	logic [7:0] sel_s2;
	logic [7:0] mask_s2;
	logic [7:0] cipher_s2;
	logic [7:0] perm_byte;

	// stage 2: permutation table lookup
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			sel_s2    <= perm_sel(key_s1.perm);
			mask_s2   <= key_s1.mask;
			cipher_s2 <= cipher_s1;
		end
	end

	// odd bits stay, even bits come through the selected arrangement
	always_comb begin
		perm_byte    = cipher_s2 & 8'hAA;
		perm_byte[6] = cipher_s2[{sel_s2[7:6], 1'b0}];
		perm_byte[4] = cipher_s2[{sel_s2[5:4], 1'b0}];
		perm_byte[2] = cipher_s2[{sel_s2[3:2], 1'b0}];
		perm_byte[0] = cipher_s2[{sel_s2[1:0], 1'b0}];
	end

	// stage 3: bit shuffle and mask
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			plain_s3 <= perm_byte ^ mask_s2;
		end
	end

endmodule

FILE: hw/rtl/address_keyed_byte_decryptor.sv
// channel  dir  tdata                                         tuser
// s_       in   address, cipher_byte, key_index, key_perm,    action
//               key_mask (48 bits)
// m_       out  opcode_byte, data_byte (16 bits)              -
//
// one transaction per cycle in while m_ keeps up; a decode is registered through
// stage 1, which reads both key rams, stage 2, which looks up the arrangement, and
// stage 3, which shuffles and masks into the output register
// key writes give no result; a decode right after
// a write to its entry sees the new key
// arst_n clears the valid bits only; the key rams hold garbage until written
// a stalled m_ side holds the pipeline stage by stage, bubbles are squeezed out
module address_keyed_byte_decryptor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // address, cipher_byte, key_index, key_perm, key_mask
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // opcode_byte, data_byte
);

	import akbd_pkg::*;

	logic [14:0]      address;
	logic [7:0]       cipher_byte;
	logic [6:0]       key_index;
	logic [4:0]       key_perm;
	logic [7:0]       key_mask;
	logic [ROW_W-1:0] row;
	key_t             wr_key;
	logic             accept;
	logic             dec_acc;
	logic             wr_acc;
	logic             ready_s1;
	logic             ready_s2;
	logic             ready_s3;
	logic             valid_s1;
	logic             valid_s2;
	logic [7:0]       cipher_s1;
	key_t             op_key_s1;
	key_t             dt_key_s1;
	stage_ctl_t       ctl;
	logic [7:0]       opcode_s3;
	logic [7:0]       data_s3;

	assign address     = s_tdata[14:0];
	assign cipher_byte = s_tdata[22:15];
	assign key_index   = s_tdata[29:23];
	assign key_perm    = s_tdata[34:30];
	assign key_mask    = s_tdata[42:35];

	assign row = {address[14], address[12], address[9], address[6], address[3], address[0]};
	assign wr_key = '{perm: key_perm, mask: key_mask};

	assign ready_s3 = !m_tvalid || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	assign accept  = s_tvalid && s_tready;
	assign dec_acc = accept && (action_t'(s_tuser) == ACT_DECODE);
	assign wr_acc  = accept && (action_t'(s_tuser) == ACT_WRITE);

	// even entries are opcode keys, odd entries data keys
	akbd_ram #(
		.WIDTH (KEY_W),
		.DEPTH (KEY_ROWS)
	) u_op_ram (
		.clk   (clk),
		.we    (wr_acc && (key_role_t'(key_index[0]) == ROLE_OPCODE)),
		.waddr (key_index[6:1]),
		.wdata (wr_key),
		.re    (dec_acc),
		.raddr (row),
		.rdata (op_key_s1)
	);

	akbd_ram #(
		.WIDTH (KEY_W),
		.DEPTH (KEY_ROWS)
	) u_dt_ram (
		.clk   (clk),
		.we    (wr_acc && (key_role_t'(key_index[0]) == ROLE_DATA)),
		.waddr (key_index[6:1]),
		.wdata (wr_key),
		.re    (dec_acc),
		.raddr (row),
		.rdata (dt_key_s1)
	);

	always_ff @(posedge clk) begin
		if (dec_acc) begin
			cipher_s1 <= cipher_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= dec_acc;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				m_tvalid <= valid_s2;
			end
		end
	end

	assign ctl = '{en_s2: ready_s2, en_s3: ready_s3};

	akbd_lane u_op_lane (
		.clk       (clk),
		.ctl       (ctl),
		.cipher_s1 (cipher_s1),
		.key_s1    (op_key_s1),
		.plain_s3  (opcode_s3)
	);

	akbd_lane u_dt_lane (
		.clk       (clk),
		.ctl       (ctl),
		.cipher_s1 (cipher_s1),
		.key_s1    (dt_key_s1),
		.plain_s3  (data_s3)
	);

	assign m_tdata = {data_s3, opcode_s3};

endmodule

FILE: tb/address_keyed_byte_decryptor_tb.sv
`timescale 1ns / 1ps

module address_keyed_byte_decryptor_tb;
	import akbd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RANDOM_ITEMS = 750;

	// source bit for output bits 6, 4, 2 and 0, per arrangement
	localparam int unsigned SRC_BIT [24][4] = '{
		'{6, 4, 2, 0}, '{4, 6, 2, 0}, '{2, 4, 6, 0}, '{0, 4, 2, 6},
		'{6, 2, 4, 0}, '{6, 0, 2, 4}, '{6, 4, 0, 2}, '{2, 6, 4, 0},
		'{4, 2, 6, 0}, '{4, 6, 0, 2}, '{6, 0, 4, 2}, '{0, 6, 4, 2},
		'{4, 0, 6, 2}, '{0, 4, 6, 2}, '{6, 2, 0, 4}, '{2, 6, 0, 4},
		'{0, 6, 2, 4}, '{2, 0, 6, 4}, '{0, 2, 6, 4}, '{4, 2, 0, 6},
		'{2, 4, 0, 6}, '{4, 0, 2, 6}, '{2, 0, 4, 6}, '{0, 2, 4, 6}
	};

	typedef struct {
		action_t    act;
		logic [14:0] addr;
		logic [7:0]  cipher;
		logic [6:0]  idx;
		logic [4:0]  perm;
		logic [7:0]  mask;
	} fetch_item_t;

	typedef struct {
		logic [7:0] opcode;
		logic [7:0] data;
	} plain_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // address, cipher_byte, key_index, key_perm, key_mask
	logic        s_tuser = 1'b0; // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // opcode_byte, data_byte

	fetch_item_t pending_fetches [$];
	plain_pair_t plain_q [$];
	logic [4:0]  perm_mem [128];
	logic [7:0]  mask_mem [128];

	int unsigned accept_cnt = 0;
	int unsigned seen_cnt = 0;
	int unsigned result_cnt = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	address_keyed_byte_decryptor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mostly short gaps, a few long ones, none at all during calm stretches
	function automatic int unsigned pick_gap(input int unsigned progress);
		int unsigned r;
		if ((progress / 150) % 4 == 1)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] unscramble(input logic [7:0] src, input logic [6:0] entry);
		int unsigned p;
		logic [7:0]  r;
		p = 32'(perm_mem[entry]);
		if (p > 23)
			p = 23;
		r = src & 8'hAA;
		r[6] = src[SRC_BIT[p][0]];
		r[4] = src[SRC_BIT[p][1]];
		r[2] = src[SRC_BIT[p][2]];
		r[0] = src[SRC_BIT[p][3]];
		return r ^ mask_mem[entry];
	endfunction

	// keeps the key store copy up to date and queues the decoded pair
	function automatic void track_fetch(input fetch_item_t it);
		logic [5:0]  row;
		plain_pair_t pp;
		if (it.act == ACT_WRITE) begin
			perm_mem[it.idx] = it.perm;
			mask_mem[it.idx] = it.mask;
		end else begin
			row = {it.addr[14], it.addr[12], it.addr[9], it.addr[6], it.addr[3], it.addr[0]};
			pp.opcode = unscramble(it.cipher, {row, ROLE_OPCODE});
			pp.data = unscramble(it.cipher, {row, ROLE_DATA});
			plain_q.push_back(pp);
		end
	endfunction

	task automatic push_key(input int unsigned idx, input int unsigned perm,
			input int unsigned mask);
		fetch_item_t it;
		it.act = ACT_WRITE;
		it.addr = 15'($urandom);
		it.cipher = 8'($urandom);
		it.idx = 7'(idx);
		it.perm = 5'(perm);
		it.mask = 8'(mask);
		pending_fetches.push_back(it);
	endtask

	task automatic push_decode(input int unsigned addr, input int unsigned cipher);
		fetch_item_t it;
		it.act = ACT_DECODE;
		it.addr = 15'(addr);
		it.cipher = 8'(cipher);
		it.idx = 7'($urandom);
		it.perm = 5'($urandom);
		it.mask = 8'($urandom);
		pending_fetches.push_back(it);
	endtask

	function automatic int unsigned rand_perm();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, 23);
		return $urandom_range(24, 31);
	endfunction

	function automatic int unsigned rand_mask();
		if ($urandom_range(0, 99) < 70)
			return $urandom_range(0, 255) & 'h55;
		return $urandom_range(0, 255);
	endfunction

	// spreads a 6-bit row over address bits 0, 3, 6, 9, 12 and 14
	function automatic int unsigned addr_of_row(input logic [5:0] row);
		logic [14:0] a;
		a = 15'($urandom);
		a[0] = row[0];
		a[3] = row[1];
		a[6] = row[2];
		a[9] = row[3];
		a[12] = row[4];
		a[14] = row[5];
		return 32'(a);
	endfunction

	// sender: moves on once the offered transaction has been taken
	always @(negedge clk) begin
		bit free;
		if (arst_n) begin
			free = !s_tvalid;
			if (s_tvalid && accept_cnt != seen_cnt) begin
				seen_cnt = accept_cnt;
				free = 1'b1;
				send_gap = pick_gap(accept_cnt);
			end
			if (free) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_fetches.size() > 0) begin
					s_tdata <= {5'b0, pending_fetches[0].mask, pending_fetches[0].perm,
						pending_fetches[0].idx, pending_fetches[0].cipher,
						pending_fetches[0].addr};
					s_tuser <= pending_fetches[0].act;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back up the pipeline
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && accept_cnt >= 300) begin
				hold_done = 1'b1;
				hold_left = 399;
				m_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				recv_stall = pick_gap(result_cnt);
				m_tready <= (recv_stall == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// input transactions are tracked before output ones are checked
	always @(posedge clk) begin
		plain_pair_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				track_fetch(pending_fetches[0]);
				void'(pending_fetches.pop_front());
				accept_cnt++;
			end
			if (m_tvalid && m_tready) begin
				result_cnt++;
				if (plain_q.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("unexpected result: opcode %02h data %02h",
							m_tdata[7:0], m_tdata[15:8]);
					mismatch_cnt++;
				end else begin
					want = plain_q.pop_front();
					if (m_tdata[7:0] !== want.opcode || m_tdata[15:8] !== want.data) begin
						if (mismatch_cnt < 10)
							$display("result %0d: expected opcode %02h data %02h, got %02h %02h",
								result_cnt, want.opcode, want.data,
								m_tdata[7:0], m_tdata[15:8]);
						mismatch_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int unsigned order [128];
		int unsigned j;
		int unsigned tmp;
		int unsigned r;
		int unsigned k;

		// directed: both end rows, saturating arrangements, odd mask bits
		push_key(0, 0, 'h00);
		push_key(1, 23, 'h55);
		push_key(126, 31, 'hFF);
		push_key(127, 24, 'hAA);
		push_decode('h0000, 'h00);
		push_decode('h0000, 'hFF);
		push_decode('h0000, 'h5A);
		push_decode('h2DB6, 'hA5);
		push_decode('h7FFF, 'h01);
		push_decode('h7FFF, 'h80);
		push_decode('h5249, 'hA5);
		push_decode('h5249, 'h3C);
		// a decode right behind a rewrite of its own entry
		push_key(0, 5, 'h14);
		push_decode('h0000, 'hC3);
		push_key(127, 0, 'h00);
		push_decode('h7FFF, 'hFF);
		push_key(1, 12, 'h41);
		push_decode('h2DB6, 'h96);

		// fill the whole key store in shuffled order before any random decode
		for (int i = 0; i < 128; i++)
			order[i] = i;
		for (int i = 127; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < 128; i++)
			push_key(order[i], rand_perm(), rand_mask());

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				push_decode($urandom_range(0, 32767), $urandom_range(0, 255));
			end else if (r < 85) begin
				push_key($urandom_range(0, 127), rand_perm(), rand_mask());
			end else begin
				// rekey an entry and hit its row straight away
				k = $urandom_range(0, 127);
				push_key(k, rand_perm(), rand_mask());
				push_decode(addr_of_row(6'(k >> 1)), $urandom_range(0, 255));
				i++;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_fetches.size() != 0)
			@(posedge clk);
		while (plain_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (plain_q.size() != 0)
			$display("%0d results never arrived", plain_q.size());
		if (mismatch_cnt == 0 && plain_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
